>>> hdl/mdpe_pkg.sv
// Shared types, constants and marker tables for the marker-delimited payload extractor.
package mdpe_pkg;

	// Default marker lengths and the largest supported marker
	localparam int START_LEN_DEF = 18;
	localparam int END_LEN_DEF   = 15;
	localparam int MARK_MAX      = 32;

	// Position counter and scan limit
	localparam int CNT_W = 24;
	localparam logic [CNT_W-1:0] SCAN_LIMIT_RST = 24'h100000;
	localparam logic [CNT_W-1:0] COUNT_MAX      = 24'hFFFFFF;

	// Status codes
	localparam logic [2:0] ST_SCAN      = 3'd0;
	localparam logic [2:0] ST_END_FOUND = 3'd1;
	localparam logic [2:0] ST_EOF       = 3'd2;
	localparam logic [2:0] ST_ZERO_ERR  = 3'd3;
	localparam logic [2:0] ST_LIM_EMPTY = 3'd4;
	localparam logic [2:0] ST_LIM_DATA  = 3'd5;

	typedef enum logic [2:0] {
		PH_SEARCH  = 3'b001,
		PH_COLLECT = 3'b010,
		PH_DONE    = 3'b100
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic [2:0] status;
	} result_t;

	// Start marker ";!@Install@!UTF-8!", zero past its end
	function automatic logic [7:0] start_mark_byte(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = ";";
			5'd1:  c = "!";
			5'd2:  c = "@";
			5'd3:  c = "I";
			5'd4:  c = "n";
			5'd5:  c = "s";
			5'd6:  c = "t";
			5'd7:  c = "a";
			5'd8:  c = "l";
			5'd9:  c = "l";
			5'd10: c = "@";
			5'd11: c = "!";
			5'd12: c = "U";
			5'd13: c = "T";
			5'd14: c = "F";
			5'd15: c = "-";
			5'd16: c = "8";
			5'd17: c = "!";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// End marker ";!@InstallEnd@!", zero past its end
	function automatic logic [7:0] end_mark_byte(input logic [4:0] idx);
		logic [7:0] c;
		case (idx)
			5'd0:  c = ";";
			5'd1:  c = "!";
			5'd2:  c = "@";
			5'd3:  c = "I";
			5'd4:  c = "n";
			5'd5:  c = "s";
			5'd6:  c = "t";
			5'd7:  c = "a";
			5'd8:  c = "l";
			5'd9:  c = "l";
			5'd10: c = "E";
			5'd11: c = "n";
			5'd12: c = "d";
			5'd13: c = "@";
			5'd14: c = "!";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

>>> hdl/mdpe_core.sv
// Window scanner: start/end marker match, payload release, position count and status.
module mdpe_core import mdpe_pkg::*; #(
	parameter int START_LEN = START_LEN_DEF,
	parameter int END_LEN   = END_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             end_of_file,
	output result_t          res
);

	localparam int WIN_LEN = (START_LEN > END_LEN) ? START_LEN : END_LEN;
	localparam int FILL_W  = $clog2(WIN_LEN + 1);

	logic [CNT_W-1:0]  scan_limit_q;
	phase_t            phase_q, phase_n;
	logic [FILL_W-1:0] fill_q, fill_n;
	logic [CNT_W-1:0]  pos_q, pos_n;
	logic              coll_q, coll_n;
	logic [7:0]        win_q [WIN_LEN];

	logic [7:0] wn [WIN_LEN];
	logic [7:0] shifted [WIN_LEN];
	logic       start_eq, end_eq;
	logic       win_load, win_shift;
	logic [CNT_W:0]   sum_one, sum_len;
	logic [CNT_W-1:0] pos_one, pos_len;
	logic       limit_hit;

	// Window with the new byte placed at the fill position, and its shifted copy
	always_comb begin
		for (int i = 0; i < WIN_LEN; i++) begin
			wn[i] = (fill_q == FILL_W'(i)) ? data_byte : win_q[i];
		end
		for (int i = 0; i < WIN_LEN - 1; i++) begin
			shifted[i] = wn[i + 1];
		end
		shifted[WIN_LEN-1] = wn[WIN_LEN-1];
	end

	// Parallel marker compares
	always_comb begin
		start_eq = 1'b1;
		for (int i = 0; i < START_LEN; i++) begin
			if (wn[i] != start_mark_byte(5'(i))) start_eq = 1'b0;
		end
		end_eq = 1'b1;
		for (int i = 0; i < END_LEN; i++) begin
			if (wn[i] != end_mark_byte(5'(i))) end_eq = 1'b0;
		end
	end

	// Saturating position increments
	assign sum_one = {1'b0, pos_q} + (CNT_W+1)'(1);
	assign sum_len = {1'b0, pos_q} + (CNT_W+1)'(START_LEN);
	assign pos_one = sum_one[CNT_W] ? COUNT_MAX : sum_one[CNT_W-1:0];
	assign pos_len = sum_len[CNT_W] ? COUNT_MAX : sum_len[CNT_W-1:0];

	assign limit_hit = (phase_q != PH_DONE) && (pos_q > scan_limit_q);

	// Next state and result for one byte
	always_comb begin
		phase_n   = phase_q;
		fill_n    = fill_q;
		pos_n     = pos_q;
		coll_n    = coll_q;
		win_load  = 1'b0;
		win_shift = 1'b0;
		res       = '0;
		res.status = ST_SCAN;

		if (limit_hit) begin
			res.status = coll_q ? ST_LIM_DATA : ST_LIM_EMPTY;
			phase_n    = PH_DONE;
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (fill_q == FILL_W'(START_LEN - 1)) begin
						if (start_eq) begin
							pos_n   = pos_len;
							phase_n = PH_COLLECT;
							fill_n  = '0;
						end else begin
							pos_n     = pos_one;
							win_shift = 1'b1;
						end
					end else begin
						fill_n   = fill_q + FILL_W'(1);
						win_load = 1'b1;
					end
				end
				PH_COLLECT: begin
					if (fill_q == FILL_W'(END_LEN - 1)) begin
						if (end_eq) begin
							res.status = ST_END_FOUND;
							phase_n    = PH_DONE;
						end else if (wn[0] == 8'h00) begin
							res.status = ST_ZERO_ERR;
							phase_n    = PH_DONE;
						end else begin
							res.payload_byte  = wn[0];
							res.payload_valid = 1'b1;
							coll_n            = 1'b1;
							pos_n             = pos_one;
							win_shift         = 1'b1;
						end
					end else begin
						fill_n   = fill_q + FILL_W'(1);
						win_load = 1'b1;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_n = PH_SEARCH;
				end
			endcase
		end

		// End of file: report if the run is still open, then rearm
		if (end_of_file) begin
			if (phase_n != PH_DONE) res.status = ST_EOF;
			phase_n = PH_SEARCH;
			fill_n  = '0;
			pos_n   = '0;
			coll_n  = 1'b0;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_limit_q <= SCAN_LIMIT_RST;
			phase_q      <= PH_SEARCH;
			fill_q       <= '0;
			pos_q        <= '0;
			coll_q       <= 1'b0;
		end else begin
			if (cfg_we) scan_limit_q <= cfg_wdata;
			if (step) begin
				phase_q <= phase_n;
				fill_q  <= fill_n;
				pos_q   <= pos_n;
				coll_q  <= coll_n;
			end
		end
	end

	// Window bytes; only written positions are ever compared
	always_ff @(posedge clk) begin
		if (step && win_load) begin
			win_q <= wn;
		end else if (step && win_shift) begin
			win_q <= shifted;
		end
	end

	a_eof_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		step && end_of_file |=> phase_q == PH_SEARCH && fill_q == '0 && pos_q == '0)
		else $error("state not rearmed after end of file");

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_DONE |-> !res.payload_valid)
		else $error("payload released after run ended");

	a_release_collected: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.payload_valid && !end_of_file |=> coll_q && phase_q == PH_COLLECT)
		else $error("release did not mark data collected");

endmodule

>>> hdl/mdpe_obuf.sv
// Two-entry output buffer between the scanner and the result stream.
module mdpe_obuf import mdpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  result_t in_data,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    valid0_q, valid1_q;
	result_t data0_q, data1_q;
	logic    push, pop;

	assign in_ready  = !valid1_q;
	assign push      = in_valid && in_ready;
	assign pop       = valid0_q && out_ready;
	assign out_valid = valid0_q;
	assign out_data  = data0_q;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid0_q <= 1'b0;
			valid1_q <= 1'b0;
		end else if (pop) begin
			if (valid1_q) begin
				valid1_q <= push;
			end else begin
				valid0_q <= push;
			end
		end else if (push) begin
			if (valid0_q) valid1_q <= 1'b1;
			else valid0_q <= 1'b1;
		end
	end

	// Entry data
	always_ff @(posedge clk) begin
		if (pop) begin
			if (valid1_q) begin
				data0_q <= data1_q;
				if (push) data1_q <= in_data;
			end else if (push) begin
				data0_q <= in_data;
			end
		end else if (push) begin
			if (valid0_q) data1_q <= in_data;
			else data0_q <= in_data;
		end
	end

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid1_q |-> valid0_q)
		else $error("second entry held without head entry");

	a_fill_second: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop && valid0_q |=> valid1_q)
		else $error("transfer lost while head stalled");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push && !valid1_q |=> !valid0_q)
		else $error("buffer not empty after last transfer");

endmodule

>>> hdl/marker_delimited_payload_extractor.sv
// A result is registered in the output buffer, behind any results held there.
// Throughput: one byte per cycle, one result per byte; the marker compares are
// combinational, and input stalls only while both buffer entries are full.
// Reset (arst_n low, asynchronous): search phase, empty window, zero positions,
// scan_limit back to 1048576, output buffer empty. No clearing pass is needed.
module marker_delimited_payload_extractor import mdpe_pkg::*; #(
	parameter int START_LEN = START_LEN_DEF,
	parameter int END_LEN   = END_LEN_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,     // scan_limit
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] data_byte
	input  logic             s_axis_tlast,  // end_of_file
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] payload_byte
	output logic [3:0]       m_axis_tuser   // [0] payload_valid, [3:1] status
);

	logic    in_fire;
	result_t core_res;
	result_t out_res;

	assign in_fire = s_axis_tvalid && s_axis_tready;

	mdpe_core #(
		.START_LEN (START_LEN),
		.END_LEN   (END_LEN)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.step        (in_fire),
		.data_byte   (s_axis_tdata),
		.end_of_file (s_axis_tlast),
		.res         (core_res)
	);

	mdpe_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (core_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	assign m_axis_tdata = out_res.payload_byte;
	assign m_axis_tuser = {out_res.status, out_res.payload_valid};

endmodule
